// ----- hw/rtl/rars_pkg.sv -----
// Shared types, constants and helpers for the range-add / range-sum array.
// Used by rars_tree, rars_ctrl and the top level; no dependencies.
`default_nettype none

package rars_pkg;

  // Storage geometry
  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int DATA_W       = 32;

  // Fixed field widths
  localparam int FUNC_W       = 2;
  localparam int IDX_FIELD_W  = 10;
  localparam int LEN_W        = 11;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 32;

  // Tree walk index: holds 1-based positions and the overshoot of an update walk
  localparam int IDX_W = ((ADDR_W + 1 > IDX_FIELD_W + 1) ? ADDR_W + 1 : IDX_FIELD_W + 1) + 1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUM  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Access request shared by both tree memories
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Lowest set bit of a tree index
  function automatic idx_t low_bit(input idx_t i);
    return i & (~i + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rars_tree.sv -----
// One Fenwick tree store: synchronous memory, one write and one read per cycle.
// Depends on rars_pkg for geometry and the request struct.
`default_nettype none

module rars_tree (
  input  logic             clk,
  input  rars_pkg::mem_req_t req,
  input  rars_pkg::word_t  wr_data,
  output rars_pkg::word_t  rd_data
);
  import rars_pkg::*;

  word_t mem [MAX_ELEMENTS];
  word_t rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rars_ctrl.sv -----
// Sequencer for the range-add / range-sum array: range checks, tree walks,
// shared multiplier, clear pass and output register. Depends on rars_pkg.
`default_nettype none

module rars_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transaction
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rars_pkg::FUNC_W-1:0]  in_func,
  input  logic [rars_pkg::IDX_FIELD_W-1:0] in_first,
  input  logic [rars_pkg::IDX_FIELD_W-1:0] in_last,
  input  rars_pkg::word_t              in_delta,
  // result transaction
  output logic                         out_valid,
  input  logic                         out_ready,
  output rars_pkg::word_t              out_value,
  // length register
  input  logic                         cfg_wen,
  input  logic [rars_pkg::LEN_W-1:0]   cfg_wdata,
  // tree memories
  output rars_pkg::mem_req_t           mem_req,
  output rars_pkg::word_t              wr_data_d,
  output rars_pkg::word_t              wr_data_w,
  input  rars_pkg::word_t              rd_data_d,
  input  rars_pkg::word_t              rd_data_w
);
  import rars_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_TOT   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam idx_t MAX_IDX = IDX_W'(MAX_ELEMENTS);

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [LEN_W-1:0]  array_length_r;
  logic [FUNC_W-1:0] func_r, func_nxt;
  idx_t              first_r, first_nxt;
  idx_t              last_r, last_nxt;
  idx_t              hi_r, hi_nxt;
  word_t             delta_r, delta_nxt;
  logic              walk_r, walk_nxt;
  idx_t              idx_r, idx_nxt;
  word_t             acc_d_r, acc_d_nxt;
  word_t             acc_w_r, acc_w_nxt;
  word_t             prod_r, prod_nxt;
  word_t             hi_tot_r, hi_tot_nxt;
  word_t             res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_data_r, out_data_nxt;

  // Range checks against the effective length
  idx_t  len_ext, len, last_c, prep_hi;
  logic  prep_empty;
  logic  is_add, in_range;
  word_t mul_a, tot, step_d, step_w;
  idx_t  mul_b, idx_lsb;

  always_comb begin
    len_ext = IDX_W'(array_length_r);
    len     = (len_ext < MAX_IDX) ? len_ext : MAX_IDX;
    last_c  = ((len != '0) && (last_r > len - 1'b1)) ? len - 1'b1 : last_r;
    if (func_r == FUNC_READ) begin
      prep_empty = (first_r >= len);
      prep_hi    = first_r + 1'b1;
    end else begin
      prep_empty = (len == '0) || (first_r >= len) || (first_r > last_c);
      prep_hi    = last_c + 1'b1;
    end
  end

  // Datapath helpers
  always_comb begin
    is_add   = (func_r == FUNC_ADD);
    in_range = (idx_r != '0) && (!is_add || (idx_r <= MAX_IDX));
    idx_lsb  = low_bit(idx_r);
    mul_a    = is_add ? delta_r : acc_d_r;
    mul_b    = (is_add == walk_r) ? hi_r : first_r;
    tot      = prod_r - acc_w_r;
    step_d   = walk_r ? (word_t'(0) - delta_r) : delta_r;
    step_w   = walk_r ? (word_t'(0) - prod_r) : prod_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    func_nxt      = func_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    hi_nxt        = hi_r;
    delta_nxt     = delta_r;
    walk_nxt      = walk_r;
    idx_nxt       = idx_r;
    acc_d_nxt     = acc_d_r;
    acc_w_nxt     = acc_w_r;
    prod_nxt      = prod_r;
    hi_tot_nxt    = hi_tot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    mem_req.rd_addr = ADDR_W'(idx_r - 1'b1);
    mem_req.wr_addr = ADDR_W'(idx_r - 1'b1);
    wr_data_d     = rd_data_d + step_d;
    wr_data_w     = rd_data_w + step_w;
    in_ready      = (state_r == ST_IDLE);

    unique case (state_r)
      // Zero both trees after reset, one entry per cycle
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_r;
        wr_data_d       = '0;
        wr_data_w       = '0;
        clr_addr_nxt    = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(MAX_ELEMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          first_nxt = IDX_W'(in_first);
          last_nxt  = IDX_W'(in_last);
          delta_nxt = in_delta;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        hi_nxt    = prep_hi;
        walk_nxt  = 1'b0;
        acc_d_nxt = '0;
        acc_w_nxt = '0;
        priority if (func_r != FUNC_ADD && func_r != FUNC_SUM && func_r != FUNC_READ) begin
          state_nxt = ST_IDLE;
        end else if (func_r == FUNC_ADD) begin
          state_nxt = prep_empty ? ST_IDLE : ST_MUL;
        end else if (prep_empty) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = prep_hi;
          state_nxt = ST_RD;
        end
      end
      // Shared multiplier: index-weighted delta, or prefix count times tree sum
      ST_MUL: begin
        prod_nxt = mul_a * DATA_W'(mul_b);
        if (is_add) begin
          idx_nxt   = walk_r ? hi_r + 1'b1 : first_r + 1'b1;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_TOT;
        end
      end
      // Issue a tree read, or finish the walk
      ST_RD: begin
        if (in_range) begin
          mem_req.rd_en = 1'b1;
          state_nxt     = ST_UPD;
        end else if (is_add) begin
          walk_nxt  = 1'b1;
          state_nxt = walk_r ? ST_IDLE : ST_MUL;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      // Read data is back: write it updated, or accumulate it
      ST_UPD: begin
        if (is_add) begin
          mem_req.wr_en = 1'b1;
          idx_nxt       = idx_r + idx_lsb;
        end else begin
          acc_d_nxt = acc_d_r + rd_data_d;
          acc_w_nxt = acc_w_r + rd_data_w;
          idx_nxt   = idx_r - idx_lsb;
        end
        state_nxt = ST_RD;
      end
      // Prefix total; second pass forms the difference of the two prefixes
      ST_TOT: begin
        if (!walk_r) begin
          hi_tot_nxt = tot;
          walk_nxt   = 1'b1;
          idx_nxt    = first_r;
          acc_d_nxt  = '0;
          acc_w_nxt  = '0;
          state_nxt  = ST_RD;
        end else begin
          res_nxt   = hi_tot_r - tot;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      out_valid_r    <= 1'b0;
      array_length_r <= LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        array_length_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    hi_r       <= hi_nxt;
    delta_r    <= delta_nxt;
    walk_r     <= walk_nxt;
    idx_r      <= idx_nxt;
    acc_d_r    <= acc_d_nxt;
    acc_w_r    <= acc_w_nxt;
    prod_r     <= prod_nxt;
    hi_tot_r   <= hi_tot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/range_add_range_sum_array.sv -----
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tuser: func; tdata: first_index, last_index, delta
// out_     out  out_tvalid/out_tready  tdata: value
// cfg_     in   cfg_wen                cfg_wdata: array_length
//
// Each tree step is a read then a write-back (or accumulate), with both trees
// in parallel. An add, a sum or an element read makes two walks over the trees;
// an empty range or unused code ends without a tree walk.
// After reset both trees are zeroed entry by entry; in_tready stays low meanwhile.
// One item is in flight at a time; a result waits in the output register while the
// next item is taken, and a full output register holds a sum or read in its last state.
// Depends on rars_pkg, rars_ctrl and rars_tree.
`default_nettype none

module range_add_range_sum_array (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic [55:0] in_tdata,   // [9:0] first_index, [19:10] last_index, [51:20] delta
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  input  logic        cfg_wen,
  input  logic [10:0] cfg_wdata   // [10:0] array_length
);
  import rars_pkg::*;

  mem_req_t mem_req;
  word_t    wr_data_d, wr_data_w, rd_data_d, rd_data_w;

  // Sequencer and datapath
  rars_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_first  (in_tdata[9:0]),
    .in_last   (in_tdata[19:10]),
    .in_delta  (in_tdata[51:20]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .wr_data_d (wr_data_d),
    .wr_data_w (wr_data_w),
    .rd_data_d (rd_data_d),
    .rd_data_w (rd_data_w)
  );

  // Point-difference tree
  rars_tree u_tree_d (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (wr_data_d),
    .rd_data (rd_data_d)
  );

  // Index-weighted difference tree
  rars_tree u_tree_w (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (wr_data_w),
    .rd_data (rd_data_w)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/rars_checker.sv -----
// Port-level checks for range_add_range_sum_array, bound to the top level.
// Depends only on the top-level port list.
`default_nettype none

module rars_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Clear pass blocks input after reset
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during clear pass");

  // One transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken back to back");

endmodule

bind range_add_range_sum_array rars_checker u_chk (.*);

`default_nettype wire
